// ===== rtl/core/msi_interrupt_file_macros.svh =====
// ----------------------------------------------------------------------------
// MSI interrupt file assertion macros
// Shared property wrappers for the checker of the interrupt file.
// ----------------------------------------------------------------------------
`ifndef MSI_INTERRUPT_FILE_MACROS_SVH
`define MSI_INTERRUPT_FILE_MACROS_SVH

// Plain clocked property with asynchronous reset disable.
`define MSIF_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("msi interrupt file check failed");

// Same wrapper with a caller message.
`define MSIF_ASSERT_MSG(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

`endif

// ===== rtl/core/msif_pkg.sv =====
// ----------------------------------------------------------------------------
// MSI interrupt file package
// Types, register codes and helper functions shared by the interrupt file.
// ----------------------------------------------------------------------------
package msif_pkg;

	localparam int MAX_HARTS_DEF = 8;
	localparam int NUM_IDS_DEF   = 64;

	localparam logic [3:0] ACTIVE_HARTS_RST = 4'd8;
	localparam logic       PRIV_MACHINE_RST = 1'b1;

	// Configuration register indexes.
	localparam logic CFG_PRIV_MACHINE = 1'b0;
	localparam logic CFG_ACTIVE_HARTS = 1'b1;

	// Request types.
	localparam logic [1:0] REQ_CSR_READ  = 2'd0;
	localparam logic [1:0] REQ_CSR_WRITE = 2'd1;
	localparam logic [1:0] REQ_MMIO_WRITE = 2'd2;
	localparam logic [1:0] REQ_MSI       = 2'd3;

	// Indirect CSR numbers.
	localparam logic [7:0] CSR_DELIVERY  = 8'h70;
	localparam logic [7:0] CSR_THRESHOLD = 8'h72;
	localparam logic [7:0] CSR_PEND_LO   = 8'h80;
	localparam logic [7:0] CSR_PEND_HI   = 8'h81;
	localparam logic [7:0] CSR_EN_LO     = 8'hC0;
	localparam logic [7:0] CSR_EN_HI     = 8'hC1;
	localparam logic [7:0] CSR_TOPEI     = 8'h44;

	localparam int HART_SHIFT = 14;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_READ,
		OP_CSR_WR,
		OP_SET_PEND
	} msif_op_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [5:0]  hart_index;
		logic [7:0]  csr_index;
		logic [19:0] mmio_offset;
		logic [31:0] write_value;
		logic [10:0] msi_ident;
	} msif_req_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        irq_update;
		logic [5:0]  irq_hart;
		logic        irq_level;
		logic        irq_line;
	} msif_rsp_t;

	// One hart's interrupt file as stored in memory.
	typedef struct packed {
		logic        deliv;
		logic [7:0]  thr;
		logic [63:0] pend;
		logic [63:0] en;
	} msif_word_t;

	typedef struct packed {
		logic       en;
		msif_word_t data;
	} msif_wr_t;

	// Bit 0 and identities at or above the implemented count are read-only zero.
	function automatic logic [63:0] impl_mask(input int num_ids);
		logic [63:0] m;
		m = '0;
		for (int i = 1; i < 64; i++) begin
			m[i] = (i < num_ids);
		end
		return m;
	endfunction

endpackage

// ===== rtl/core/msif_store.sv =====
// ----------------------------------------------------------------------------
// MSI interrupt file store
// One word per hart in a synchronous memory, with per-entry valid bits so
// that entries never written read as all zero after reset.
// ----------------------------------------------------------------------------
module msif_store #(
	parameter int DEPTH = msif_pkg::MAX_HARTS_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rd_en,
	input  logic [AW-1:0]       rd_addr,
	output msif_pkg::msif_word_t rd_word,
	input  msif_pkg::msif_wr_t  wr,
	input  logic [AW-1:0]       wr_addr
);

	msif_pkg::msif_word_t mem [DEPTH];
	msif_pkg::msif_word_t rd_data_q;
	logic [DEPTH-1:0]     valid_q;
	logic                 rd_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr.en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr_addr] <= wr.data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_word = rd_valid_q ? rd_data_q : '0;

endmodule

// ===== rtl/core/msi_interrupt_file.sv =====
// ----------------------------------------------------------------------------
// MSI interrupt file
// Per-hart delivery enable, threshold and pending/enable masks with CSR,
// MMIO seteipnum and direct MSI access.
// ----------------------------------------------------------------------------
// Usage:
// A request is taken at a rising edge with start high and busy low. The
// hart's file is read from memory at that edge, modified and written back in
// the next cycle, and the top identity is resolved in the cycle after that.
// The result appears on rsp with done high for exactly one cycle, from the
// result register after the top identity search; the receiver cannot hold it off.
// busy is high in the cycle after a transfer, so a new request is not
// taken until the last one has passed the read-modify-write of the hart
// memory, a read and then a write back. A request that follows therefore
// always reads the updated entry.
// Configuration writes (cfg_we, cfg_index, cfg_wdata) take effect at once; the user
// must make them while no request is in flight, the block does not enforce it.
// After reset every hart file reads as all zero through per-hart valid bits,
// with no clearing pass; the machine line is selected and eight harts are
// present.
// ----------------------------------------------------------------------------
module msi_interrupt_file #(
	parameter int MAX_HARTS = msif_pkg::MAX_HARTS_DEF,
	parameter int NUM_IDS   = msif_pkg::NUM_IDS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  msif_pkg::msif_req_t req,
	output logic                done,
	output msif_pkg::msif_rsp_t rsp,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [3:0]          cfg_wdata
);

	localparam int          AW   = (MAX_HARTS > 1) ? $clog2(MAX_HARTS) : 1;
	localparam logic [63:0] IMPL = msif_pkg::impl_mask(NUM_IDS);

	// Configuration registers.
	logic       priv_q;
	logic [3:0] active_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			priv_q   <= msif_pkg::PRIV_MACHINE_RST;
			active_q <= msif_pkg::ACTIVE_HARTS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				msif_pkg::CFG_PRIV_MACHINE: priv_q <= cfg_wdata[0];
				msif_pkg::CFG_ACTIVE_HARTS: active_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Request decode at the transfer.
	logic              accept;
	logic [5:0]        tgt_hart;
	logic [10:0]       tgt_id;
	logic              hart_ok;
	logic              id_ok;
	msif_pkg::msif_op_t op_in;

	assign accept = start && !busy;

	always_comb begin
		if (req.req_type == msif_pkg::REQ_MMIO_WRITE) begin
			tgt_hart = req.mmio_offset[19:msif_pkg::HART_SHIFT];
			tgt_id   = req.write_value[10:0];
		end else begin
			tgt_hart = req.hart_index;
			tgt_id   = req.msi_ident;
		end
		hart_ok = {1'b0, tgt_hart} < 7'(MAX_HARTS);
		id_ok   = (tgt_id != '0) && (tgt_id < 11'(NUM_IDS));
		case (req.req_type)
			msif_pkg::REQ_CSR_READ:  op_in = hart_ok ? msif_pkg::OP_READ : msif_pkg::OP_NONE;
			msif_pkg::REQ_CSR_WRITE: op_in = hart_ok ? msif_pkg::OP_CSR_WR : msif_pkg::OP_NONE;
			msif_pkg::REQ_MMIO_WRITE: begin
				op_in = (hart_ok && id_ok && (req.mmio_offset[msif_pkg::HART_SHIFT-1:0] == '0))
					? msif_pkg::OP_SET_PEND : msif_pkg::OP_NONE;
			end
			default: op_in = (hart_ok && id_ok) ? msif_pkg::OP_SET_PEND : msif_pkg::OP_NONE;
		endcase
	end

	// Stage 1: memory data arrives, modify and write back.
	logic               vld_s1;
	msif_pkg::msif_op_t op_s1;
	logic [5:0]         hart_s1;
	logic [7:0]         idx_s1;
	logic [31:0]        val_s1;
	logic [5:0]         sid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= op_in;
			hart_s1 <= tgt_hart;
			idx_s1  <= req.csr_index;
			val_s1  <= req.write_value;
			sid_s1  <= tgt_id[5:0];
		end
	end

	assign busy = vld_s1;

	msif_pkg::msif_word_t cur_word;
	msif_pkg::msif_word_t new_word;
	msif_pkg::msif_word_t eval_word;
	msif_pkg::msif_wr_t   wr;
	logic [31:0]          rdv;
	logic                 emit;

	msif_store #(
		.DEPTH (MAX_HARTS),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept && hart_ok),
		.rd_addr (tgt_hart[AW-1:0]),
		.rd_word (cur_word),
		.wr      (wr),
		.wr_addr (hart_s1[AW-1:0])
	);

	always_comb begin
		new_word = cur_word;
		wr.en    = 1'b0;
		case (op_s1)
			msif_pkg::OP_CSR_WR: begin
				case (idx_s1)
					msif_pkg::CSR_DELIVERY: begin
						new_word.deliv = val_s1[0];
						wr.en = 1'b1;
					end
					msif_pkg::CSR_THRESHOLD: begin
						new_word.thr = val_s1[7:0];
						wr.en = 1'b1;
					end
					msif_pkg::CSR_PEND_LO: begin
						new_word.pend = {cur_word.pend[63:32], val_s1} & IMPL;
						wr.en = 1'b1;
					end
					msif_pkg::CSR_PEND_HI: begin
						new_word.pend = {val_s1, cur_word.pend[31:0]} & IMPL;
						wr.en = 1'b1;
					end
					msif_pkg::CSR_EN_LO: begin
						new_word.en = {cur_word.en[63:32], val_s1} & IMPL;
						wr.en = 1'b1;
					end
					msif_pkg::CSR_EN_HI: begin
						new_word.en = {val_s1, cur_word.en[31:0]} & IMPL;
						wr.en = 1'b1;
					end
					default: ;
				endcase
			end
			msif_pkg::OP_SET_PEND: begin
				new_word.pend = cur_word.pend | (64'd1 << sid_s1);
				wr.en = 1'b1;
			end
			default: ;
		endcase
		wr.en   = wr.en && vld_s1;
		wr.data = new_word;

		rdv = '0;
		if (op_s1 == msif_pkg::OP_READ) begin
			case (idx_s1)
				msif_pkg::CSR_DELIVERY:  rdv = {31'd0, cur_word.deliv};
				msif_pkg::CSR_THRESHOLD: rdv = {24'd0, cur_word.thr};
				msif_pkg::CSR_PEND_LO:   rdv = cur_word.pend[31:0];
				msif_pkg::CSR_PEND_HI:   rdv = cur_word.pend[63:32];
				msif_pkg::CSR_EN_LO:     rdv = cur_word.en[31:0];
				msif_pkg::CSR_EN_HI:     rdv = cur_word.en[63:32];
				default:                 rdv = '0;
			endcase
		end

		// Levels are evaluated on the state after the write.
		eval_word = wr.en ? new_word : cur_word;
		emit      = wr.en && ({2'b00, active_q} > hart_s1);
	end

	// Stage 2: top identity search.
	logic        vld_s2;
	logic        topei_s2;
	logic        upd_s2;
	logic [5:0]  hart_s2;
	logic [31:0] rdv_s2;
	logic [63:0] act_s2;
	logic        deliv_s2;
	logic [7:0]  thr_s2;
	logic        line_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			topei_s2 <= (op_s1 == msif_pkg::OP_READ) && (idx_s1 == msif_pkg::CSR_TOPEI);
			upd_s2   <= emit;
			hart_s2  <= hart_s1;
			rdv_s2   <= rdv;
			act_s2   <= eval_word.pend & eval_word.en & IMPL;
			deliv_s2 <= eval_word.deliv;
			thr_s2   <= eval_word.thr;
			line_s2  <= priv_q;
		end
	end

	logic [63:0] lowbit;
	logic [5:0]  low_id;
	logic        fire;
	logic [5:0]  top_id;

	always_comb begin
		// Isolate the lowest set bit, then encode its position.
		lowbit = act_s2 & (~act_s2 + 64'd1);
		low_id = '0;
		for (int b = 0; b < 6; b++) begin
			for (int i = 0; i < 64; i++) begin
				if (((i >> b) & 1) == 1) begin
					low_id[b] = low_id[b] | lowbit[i];
				end
			end
		end
		fire   = deliv_s2 && (act_s2 != '0) && ((thr_s2 == '0) || ({2'b00, low_id} < thr_s2));
		top_id = fire ? low_id : '0;
	end

	// Result register.
	logic                done_q;
	msif_pkg::msif_rsp_t rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s2) begin
			rsp_q.read_data  <= topei_s2 ? {10'd0, top_id, 10'd0, top_id} : rdv_s2;
			rsp_q.irq_update <= upd_s2;
			rsp_q.irq_hart   <= upd_s2 ? hart_s2 : '0;
			rsp_q.irq_level  <= upd_s2 && fire;
			rsp_q.irq_line   <= upd_s2 && line_s2;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

// ===== rtl/core/msi_interrupt_file_checker.sv =====
// ----------------------------------------------------------------------------
// MSI interrupt file checker
// Port-level timing and result consistency checks, bound to the top level.
// ----------------------------------------------------------------------------
`include "msi_interrupt_file_macros.svh"

module msi_interrupt_file_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input logic                done,
	input msif_pkg::msif_rsp_t rsp
);

	// Every transfer is followed by busy in the next cycle.
	`MSIF_ASSERT(a_busy_after_xfer, clk, arst_n, (start && !busy) |=> busy)

	// Each transfer out of reset yields a result, and a result shows only for a transfer.
	`MSIF_ASSERT_MSG(a_fixed_latency, clk, arst_n, done == $past(arst_n && start && !busy, 3), "result timing broken")

	// Without a level update the interrupt fields stay zero.
	`MSIF_ASSERT(a_quiet_fields, clk, arst_n, (done && !rsp.irq_update) |-> (rsp.irq_hart == 6'd0 && !rsp.irq_level && !rsp.irq_line))

	// A level update never carries read data.
	`MSIF_ASSERT(a_update_no_data, clk, arst_n, (done && rsp.irq_update) |-> (rsp.read_data == 32'd0))

endmodule

bind msi_interrupt_file msi_interrupt_file_checker u_checker (.*);
